@@ sv/bbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_pkg: shared types and constants of the biquad filter section
// Sequencer states, datapath control codes and register indexes.
// ----------------------------------------------------------------------------
package bbf_pkg;

	localparam int DELAY_W   = 32;
	localparam int ACC_W     = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SECTION_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_COEF_ONE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_COEF_TWO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF_ONE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF_TWO = 3'd4;

	localparam logic signed [ACC_W-1:0] DELAY_MAX = 64'sd2147483647;
	localparam logic signed [ACC_W-1:0] DELAY_MIN = -64'sd2147483648;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P2,
		ST_ACC_P2,
		ST_ROUND_W,
		ST_MUL_G,
		ST_MUL_Z1,
		ST_MUL_Z2,
		ST_ACC_Z2,
		ST_ROUND_Y
	} bbf_state_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_LOAD_PROD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		OPA_S0,
		OPA_S1,
		OPA_W
	} opa_sel_t;

	typedef enum logic [2:0] {
		OPB_GAIN,
		OPB_Z1,
		OPB_Z2,
		OPB_P1,
		OPB_P2
	} opb_sel_t;

	typedef struct packed {
		logic    mul_en;
		acc_op_t acc_op;
	} mac_ctrl_t;

endpackage

@@ sv/bbf_sample_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_sample_in_if: input sample channel
// Valid/ready channel carrying one signed sample per transfer.
// ----------------------------------------------------------------------------
interface bbf_sample_in_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

@@ sv/bbf_sample_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_sample_out_if: output sample channel
// Valid/ready channel carrying one filtered signed sample per transfer.
// ----------------------------------------------------------------------------
interface bbf_sample_out_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

@@ sv/bbf_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_cfg_if: coefficient write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bbf_cfg_if
	import bbf_pkg::*;
#(
	parameter int COEF_WIDTH = 24
);
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [COEF_WIDTH-1:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ sv/butterworth_biquad_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// butterworth_biquad_filter: second-order IIR section, direct form II
// Filters signed samples with five Q3.20 coefficients using one shared
// multiplier and a saturating 64-bit accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   src  - input samples; one transfer starts one filter step.
//   dst  - filtered samples; one transfer per input sample, in order.
//   cfg  - coefficient writes (0 gain, 1/2 zero coefs, 3/4 pole coefs);
//          always ready, indexes past the list are dropped. Write only
//          while the block is idle.
// Timing: src.ready is high only in the idle state. A sample is taken,
//   then eight sequencer steps follow (two feedback products, rescale of
//   w, three output products, rescale of y), all through the one
//   multiplier; dst.valid rises once the last step registers the result.
//   No new sample is taken until the sequencer is back in idle.
// Stall: the result sits in an output register; if the previous result
//   is still untaken when the next one finishes, hold in the last step
//   until dst.ready, then advance. Delays update only at that point.
// Reset: delays clear to zero, gain resets to 1.0, other coefs to zero,
//   the output register empties.
// ----------------------------------------------------------------------------
module butterworth_biquad_filter
	import bbf_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bbf_sample_in_if.sink         src,
	bbf_sample_out_if.source      dst,
	bbf_cfg_if.sink               cfg
);

	localparam int FRAC = COEF_WIDTH - 4;
	localparam logic signed [COEF_WIDTH-1:0] GAIN_ONE = COEF_WIDTH'(1) << FRAC;
	localparam logic signed [ACC_W-1:0] SMP_MAX = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SMP_MIN = -SMP_MAX - ACC_W'(1);

	// coefficient registers
	logic signed [COEF_WIDTH-1:0] section_gain_q;
	logic signed [COEF_WIDTH-1:0] zero_coef_one_q;
	logic signed [COEF_WIDTH-1:0] zero_coef_two_q;
	logic signed [COEF_WIDTH-1:0] pole_coef_one_q;
	logic signed [COEF_WIDTH-1:0] pole_coef_two_q;

	// filter state
	logic signed [DELAY_W-1:0]      delay_first_q;
	logic signed [DELAY_W-1:0]      delay_second_q;
	logic signed [DELAY_W-1:0]      w_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	logic                           out_valid_q;

	bbf_state_t state_q, state_d;

	// sequencer outputs
	mac_ctrl_t ctrl;
	opa_sel_t  opa_sel;
	opb_sel_t  opb_sel;
	logic      w_load;
	logic      y_fire;

	logic                         in_xfer;
	logic                         out_free;
	logic signed [DELAY_W-1:0]    opa;
	logic signed [COEF_WIDTH-1:0] opb;
	logic signed [ACC_W-1:0]      load_val;
	logic signed [ACC_W-1:0]      scaled;
	logic signed [DELAY_W-1:0]    w_sat;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	assign src.ready = (state_q == ST_IDLE);
	assign in_xfer   = src.valid && src.ready;
	assign out_free  = !out_valid_q || dst.ready;
	assign cfg.ready = 1'b1;

	assign dst.valid      = out_valid_q;
	assign dst.sample_out = out_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_gain_q  <= GAIN_ONE;
			zero_coef_one_q <= '0;
			zero_coef_two_q <= '0;
			pole_coef_one_q <= '0;
			pole_coef_two_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				REG_SECTION_GAIN:  section_gain_q  <= signed'(cfg.wr_data);
				REG_ZERO_COEF_ONE: zero_coef_one_q <= signed'(cfg.wr_data);
				REG_ZERO_COEF_TWO: zero_coef_two_q <= signed'(cfg.wr_data);
				REG_POLE_COEF_ONE: pole_coef_one_q <= signed'(cfg.wr_data);
				REG_POLE_COEF_TWO: pole_coef_two_q <= signed'(cfg.wr_data);
				default: ; // drop writes past the register list
			endcase
		end
	end

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_xfer) state_d = ST_MUL_P2;
			ST_MUL_P2:  state_d = ST_ACC_P2;
			ST_ACC_P2:  state_d = ST_ROUND_W;
			ST_ROUND_W: state_d = ST_MUL_G;
			ST_MUL_G:   state_d = ST_MUL_Z1;
			ST_MUL_Z1:  state_d = ST_MUL_Z2;
			ST_MUL_Z2:  state_d = ST_ACC_Z2;
			ST_ACC_Z2:  state_d = ST_ROUND_Y;
			ST_ROUND_Y: if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Products run one step ahead of the accumulator: the product taken in
	// one step is loaded, added or subtracted in the next.
	always_comb begin
		ctrl.mul_en = 1'b0;
		ctrl.acc_op = ACC_HOLD;
		opa_sel     = OPA_S0;
		opb_sel     = OPB_P1;
		w_load      = 1'b0;
		y_fire      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// load x aligned to product scale, start s0*p1
				if (in_xfer) begin
					ctrl.mul_en = 1'b1;
					ctrl.acc_op = ACC_LOAD;
				end
			end
			ST_MUL_P2: begin
				ctrl.mul_en = 1'b1;
				ctrl.acc_op = ACC_SUB;
				opa_sel     = OPA_S1;
				opb_sel     = OPB_P2;
			end
			ST_ACC_P2: begin
				ctrl.acc_op = ACC_SUB;
			end
			ST_ROUND_W: begin
				w_load = 1'b1;
			end
			ST_MUL_G: begin
				ctrl.mul_en = 1'b1;
				opa_sel     = OPA_W;
				opb_sel     = OPB_GAIN;
			end
			ST_MUL_Z1: begin
				ctrl.mul_en = 1'b1;
				ctrl.acc_op = ACC_LOAD_PROD;
				opa_sel     = OPA_S0;
				opb_sel     = OPB_Z1;
			end
			ST_MUL_Z2: begin
				ctrl.mul_en = 1'b1;
				ctrl.acc_op = ACC_ADD;
				opa_sel     = OPA_S1;
				opb_sel     = OPB_Z2;
			end
			ST_ACC_Z2: begin
				ctrl.acc_op = ACC_ADD;
			end
			ST_ROUND_Y: begin
				y_fire = out_free;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------ operand muxes
	always_comb begin
		unique case (opa_sel)
			OPA_S0:  opa = delay_first_q;
			OPA_S1:  opa = delay_second_q;
			OPA_W:   opa = w_q;
			default: opa = delay_first_q;
		endcase
	end

	always_comb begin
		unique case (opb_sel)
			OPB_GAIN: opb = section_gain_q;
			OPB_Z1:   opb = zero_coef_one_q;
			OPB_Z2:   opb = zero_coef_two_q;
			OPB_P1:   opb = pole_coef_one_q;
			OPB_P2:   opb = pole_coef_two_q;
			default:  opb = pole_coef_one_q;
		endcase
	end

	assign load_val = ACC_W'(src.sample_in) <<< FRAC;

	bbf_mac #(
		.COEF_WIDTH(COEF_WIDTH)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.opa      (opa),
		.opb      (opb),
		.load_val (load_val),
		.scaled   (scaled)
	);

	// ------------------------------------------------------------ clamping
	always_comb begin
		if (scaled > DELAY_MAX) begin
			w_sat = DELAY_MAX[DELAY_W-1:0];
		end else if (scaled < DELAY_MIN) begin
			w_sat = DELAY_MIN[DELAY_W-1:0];
		end else begin
			w_sat = scaled[DELAY_W-1:0];
		end
	end

	always_comb begin
		if (scaled > SMP_MAX) begin
			y_sat = SMP_MAX[SAMPLE_WIDTH-1:0];
		end else if (scaled < SMP_MIN) begin
			y_sat = SMP_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y_sat = scaled[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (w_load) begin
			w_q <= w_sat;
		end
		if (y_fire) begin
			out_q <= y_sat;
		end
	end

	// shift w into the delay pair once the result is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_first_q  <= '0;
			delay_second_q <= '0;
		end else if (y_fire) begin
			delay_second_q <= delay_first_q;
			delay_first_q  <= w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (y_fire) begin
			out_valid_q <= 1'b1;
		end else if (dst.valid && dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !src.ready)
		else $error("input taken again right after a transfer");

	a_result_from_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst.valid) |-> $past(state_q == ST_ROUND_Y))
		else $error("result raised outside the final step");

	a_delays_move_at_result: assert property (@(posedge clk) disable iff (!arst_n)
		!y_fire |=> $stable(delay_first_q) && $stable(delay_second_q))
		else $error("delay pair changed without a result");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND_Y) && dst.valid && !dst.ready |=> state_q == ST_ROUND_Y)
		else $error("sequencer left final step while output stalled");
`endif

endmodule

@@ sv/bbf_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbf_mac: shared multiply and saturating accumulate unit
// One registered 32 x COEF multiplier feeding a 64-bit saturating
// accumulator, plus the round-half-up rescale of the accumulator.
// ----------------------------------------------------------------------------
module bbf_mac
	import bbf_pkg::*;
#(
	parameter int COEF_WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mac_ctrl_t                    ctrl,
	input  logic signed [DELAY_W-1:0]    opa,
	input  logic signed [COEF_WIDTH-1:0] opb,
	input  logic signed [ACC_W-1:0]      load_val,
	output logic signed [ACC_W-1:0]      scaled
);

	localparam int FRAC   = COEF_WIDTH - 4;
	localparam int PROD_W = DELAY_W + COEF_WIDTH;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return signed'(s[ACC_W-1:0]);
	endfunction

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rounded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1 <= '0;
		end else if (ctrl.mul_en) begin
			prod_s1 <= opa * opb;
		end
	end

	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (ctrl.acc_op)
				ACC_LOAD:      acc_q <= load_val;
				ACC_LOAD_PROD: acc_q <= prod_ext;
				ACC_ADD:       acc_q <= sat_add(acc_q, prod_ext);
				ACC_SUB:       acc_q <= sat_add(acc_q, -prod_ext);
				default:       acc_q <= acc_q;
			endcase
		end
	end

	// round half up, then shift toward minus infinity
	assign rounded = sat_add(acc_q, HALF);
	assign scaled  = rounded >>> FRAC;

endmodule

@@ tb/tb_butterworth_biquad_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_butterworth_biquad_filter: self-checking bench for the biquad section
// Walks a short table of directed samples and coefficient writes, then runs
// blocks of random samples under changing coefficient sets and idle
// patterns. Every filtered sample is checked against a typed-in value or
// an in-bench fixed point model of the direct form II section.
// ----------------------------------------------------------------------------
module tb_butterworth_biquad_filter;
	import bbf_pkg::*;

	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 24;
	localparam int FRAC     = COEF_W - 4;

	// Index used on sample rows where no register applies, and two indexes
	// past the end of the register list (the block drops those writes).
	localparam logic [CFG_IDX_W-1:0] IDX_NONE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIVE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_SEVEN = 3'd7;

	localparam longint ACC_TOP = 64'sh7fff_ffff_ffff_ffff;
	localparam longint ACC_BOT = 64'sh8000_0000_0000_0000;
	localparam longint OUT_TOP = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint OUT_BOT = -(longint'(1) <<< (SAMPLE_W - 1));

	localparam int BLOCKS       = 15;
	localparam int BLOCK_ITEMS  = 50;
	localparam int SETTLE_TICKS = 12;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [COEF_W-1:0]    value;     // sample or register data
		logic                 known;     // expected output typed in below
		logic [SAMPLE_W-1:0]  known_out;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 29;

	// Reset coefficients pass samples straight through, so the first rows
	// and the gain extremes have outputs that can be written down directly.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, IDX_NONE,          24'h000000, 1'b1, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h7fffff, 1'b1, 24'h7fffff},
		'{ROW_SAMPLE, IDX_NONE,          24'h800000, 1'b1, 24'h800000},
		'{ROW_SAMPLE, IDX_NONE,          24'h000001, 1'b1, 24'h000001},
		'{ROW_SAMPLE, IDX_NONE,          24'hffffff, 1'b1, 24'hffffff},
		// gain -8.0: full scale in saturates the output both ways
		'{ROW_WRITE,  REG_SECTION_GAIN,  24'h800000, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h7fffff, 1'b1, 24'h800000},
		'{ROW_SAMPLE, IDX_NONE,          24'h800000, 1'b1, 24'h7fffff},
		'{ROW_SAMPLE, IDX_NONE,          24'h000000, 1'b1, 24'h000000},
		// gain just under 8.0 on one eighth of full scale
		'{ROW_WRITE,  REG_SECTION_GAIN,  24'h7fffff, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h100000, 1'b1, 24'h7fffff},
		// feedforward extremes
		'{ROW_WRITE,  REG_SECTION_GAIN,  24'h100000, 1'b0, 24'h000000},
		'{ROW_WRITE,  REG_ZERO_COEF_ONE, 24'h7fffff, 1'b0, 24'h000000},
		'{ROW_WRITE,  REG_ZERO_COEF_TWO, 24'h800000, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h7fffff, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h800000, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h400000, 1'b0, 24'h000000},
		// feedback extremes drive w into its 32-bit clamp
		'{ROW_WRITE,  REG_POLE_COEF_ONE, 24'h800000, 1'b0, 24'h000000},
		'{ROW_WRITE,  REG_POLE_COEF_TWO, 24'h7fffff, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h7fffff, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h7fffff, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h7fffff, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h7fffff, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h800000, 1'b0, 24'h000000},
		// writes past the register list must leave the coefficients alone
		'{ROW_WRITE,  REG_SPARE_FIVE,    24'h123456, 1'b0, 24'h000000},
		'{ROW_WRITE,  REG_SPARE_SEVEN,   24'hffffff, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h400000, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'hc00000, 1'b0, 24'h000000},
		'{ROW_SAMPLE, IDX_NONE,          24'h000000, 1'b0, 24'h000000}
	};

	logic clk;
	logic arst_n;

	bbf_sample_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) src_if ();
	bbf_sample_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) dst_if ();
	bbf_cfg_if        #(.COEF_WIDTH(COEF_W))     cfg_if ();

	butterworth_biquad_filter #(
		.SAMPLE_WIDTH(SAMPLE_W),
		.COEF_WIDTH  (COEF_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.src   (src_if),
		.dst   (dst_if),
		.cfg   (cfg_if)
	);

	// Bench copy of the coefficient registers and the delay pair.
	logic signed [COEF_W-1:0]  gain_q;
	logic signed [COEF_W-1:0]  zero_one_q;
	logic signed [COEF_W-1:0]  zero_two_q;
	logic signed [COEF_W-1:0]  pole_one_q;
	logic signed [COEF_W-1:0]  pole_two_q;
	logic signed [DELAY_W-1:0] delay_first_q;
	logic signed [DELAY_W-1:0] delay_second_q;

	logic [SAMPLE_W-1:0] due_samples [$];   // filtered samples still to come

	// Directed rows with a typed-in output hand it over here.
	logic                known_pending;
	logic [SAMPLE_W-1:0] known_value;

	int src_idle_pct;
	int dst_idle_pct;
	int mismatches;

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Fixed point model of one filter step
	// ------------------------------------------------------------------
	function automatic longint sat_sum(input longint a, input longint b);
		longint s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			s = a[63] ? ACC_BOT : ACC_TOP;
		return s;
	endfunction

	// Add half an LSB, then shift toward minus infinity.
	function automatic longint rescale(input longint a);
		return sat_sum(a, longint'(1) <<< (FRAC - 1)) >>> FRAC;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [SAMPLE_W-1:0] filter_sample(input logic signed [SAMPLE_W-1:0] x);
		longint s0;
		longint s1;
		longint acc;
		longint w;
		longint y;
		s0 = longint'(delay_first_q);
		s1 = longint'(delay_second_q);

		// Feedback path: w = x - s0*p1 - s1*p2, clamped to 32 bits.
		acc = longint'(x) <<< FRAC;
		acc = sat_sum(acc, -(s0 * longint'(pole_one_q)));
		acc = sat_sum(acc, -(s1 * longint'(pole_two_q)));
		w   = clip(rescale(acc), DELAY_MIN, DELAY_MAX);

		// Feedforward path: y = w*g + s0*z1 + s1*z2, clamped to sample range.
		acc = w * longint'(gain_q);
		acc = sat_sum(acc, s0 * longint'(zero_one_q));
		acc = sat_sum(acc, s1 * longint'(zero_two_q));
		y   = clip(rescale(acc), OUT_BOT, OUT_TOP);

		delay_second_q = delay_first_q;
		delay_first_q  = w[DELAY_W-1:0];
		return y[SAMPLE_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sample every handshake at the rising edge. Check the output
	// transfer first, then track register writes, then predict for the
	// input transfer of the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q         = 24'sh100000;
			zero_one_q     = '0;
			zero_two_q     = '0;
			pole_one_q     = '0;
			pole_two_q     = '0;
			delay_first_q  = '0;
			delay_second_q = '0;
		end else begin
			if (dst_if.valid && dst_if.ready) begin
				if (due_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: output 0x%06h with nothing expected", $realtime,
							dst_if.sample_out);
				end else begin
					if (dst_if.sample_out !== due_samples[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: sample_out expected 0x%06h got 0x%06h",
								$realtime, due_samples[0], dst_if.sample_out);
					end
					void'(due_samples.pop_front());
				end
			end

			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.reg_index)
					REG_SECTION_GAIN:  gain_q     = cfg_if.wr_data;
					REG_ZERO_COEF_ONE: zero_one_q = cfg_if.wr_data;
					REG_ZERO_COEF_TWO: zero_two_q = cfg_if.wr_data;
					REG_POLE_COEF_ONE: pole_one_q = cfg_if.wr_data;
					REG_POLE_COEF_TWO: pole_two_q = cfg_if.wr_data;
					default: ;   // past the list: dropped
				endcase
			end

			if (src_if.valid && src_if.ready) begin
				logic [SAMPLE_W-1:0] predicted;
				predicted = filter_sample(src_if.sample_in);
				// Still advance the model state on rows with a typed-in output.
				due_samples.push_back(known_pending ? known_value : predicted);
			end
		end
	end

	// Receiver: stall at random, changing only on the falling edge.
	always @(negedge clk) begin
		dst_if.ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// ------------------------------------------------------------------
	// Stimulus tasks; all are entered and left on a falling edge.
	// ------------------------------------------------------------------
	task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic known,
		input logic [SAMPLE_W-1:0] known_out);
		// At random, idle the sender first with valid low.
		if ($urandom_range(99) < src_idle_pct) begin
			src_if.valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(negedge clk);
		end
		known_pending     = known;
		known_value       = known_out;
		src_if.valid     <= 1'b1;
		src_if.sample_in <= x;
		do
			@(posedge clk);
		while (!src_if.ready);
		@(negedge clk);
	endtask

	// Hold off the sender until every filtered sample has come back.
	task automatic drain_filter();
		src_if.valid <= 1'b0;
		@(negedge clk);
		while (due_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	// One register transfer; valid is lowered before the task returns, which keeps
	// back-to-back writes from lowering and raising valid in one step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_if.valid     <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.wr_data   <= data;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [COEF_W-1:0] extreme_coef();
		case ($urandom_range(3))
			0:       return 24'h800000;
			1:       return 24'h7fffff;
			2:       return 24'h000000;
			default: return 24'h100000;
		endcase
	endfunction

	// Pick one coefficient set per block: low-pass and high-pass designs at
	// an eighth of the sample rate, mild random, full random, extremes.
	task automatic load_coef_set(input int mode);
		logic [COEF_W-1:0] c [5];
		case (mode)
			0: c = '{24'd102373, 24'd204746, 24'd102373, -24'sd988606, 24'd349525};
			1: c = '{24'd596637, -24'sd1193274, 24'd596637, -24'sd988606, 24'd349525};
			2: begin
				foreach (c[i])
					c[i] = COEF_W'($urandom_range(2097152) - 1048576);
			end
			3: begin
				foreach (c[i])
					c[i] = COEF_W'($urandom);
			end
			default: begin
				foreach (c[i])
					c[i] = extreme_coef();
			end
		endcase
		write_reg(REG_SECTION_GAIN,  c[0]);
		write_reg(REG_ZERO_COEF_ONE, c[1]);
		write_reg(REG_ZERO_COEF_TWO, c[2]);
		write_reg(REG_POLE_COEF_ONE, c[3]);
		write_reg(REG_POLE_COEF_TWO, c[4]);
		// Now and then throw in a write that lands on any index at all.
		if ($urandom_range(2) == 0)
			write_reg(3'($urandom_range(7)), 24'($urandom));
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom_range(1) ? 24'h7fffff : 24'h800000;
		if (pick < 30)
			return 24'($urandom_range(2047) - 1024);
		return 24'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		src_if.valid     = 1'b0;
		src_if.sample_in = '0;
		dst_if.ready     = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.reg_index = IDX_NONE;
		cfg_if.wr_data   = '0;
		known_pending    = 1'b0;
		known_value      = '0;
		src_idle_pct     = 25;
		dst_idle_pct     = 67;
		mismatches       = 0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table: drain before each write so the block is idle.
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				drain_filter();
				write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
			end else begin
				send_sample(directed_rows[r].value, directed_rows[r].known,
					directed_rows[r].known_out);
			end
		end

		// Random blocks: swap idle roles a third of the way in, then stop idling.
		for (int b = 0; b < BLOCKS; b++) begin
			drain_filter();
			if (b == BLOCKS / 3) begin
				src_idle_pct = 67;
				dst_idle_pct = 25;
			end else if (b == 2 * BLOCKS / 3) begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			load_coef_set(b % 5);
			for (int n = 0; n < BLOCK_ITEMS; n++)
				send_sample(random_sample(), 1'b0, '0);
		end

		// Let the last results drain, then report.
		drain_filter();
		if (mismatches == 0 && due_samples.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
